// ===== sv/rfd_pkg.sv =====
package rfd_pkg;

   localparam int ID_BYTES = 4;

   localparam logic [15:0] OFS_LEN   = 16'(4 + ID_BYTES);
   localparam logic [15:0] OFS_CNT   = 16'(6 + ID_BYTES);
   localparam logic [15:0] OFS_STAMP = 16'(8 + ID_BYTES);
   localparam logic [15:0] OFS_SRC   = 16'(12 + ID_BYTES);
   localparam logic [15:0] OFS_DST   = 16'(13 + ID_BYTES);
   localparam logic [15:0] OFS_CHK   = 16'(14 + ID_BYTES);
   localparam logic [15:0] HDR_SIZE  = 16'(16 + ID_BYTES);
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam logic [7:0] MARKER_RESET = 8'hF0;

   localparam int RSP_DATA_WIDTH = 128;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_OPCODE   = 3'd2,
      ST_LENGTH   = 3'd3,
      ST_CHECKSUM = 3'd4
   } status_type;

   typedef struct packed {
      logic       is_payload;
      logic [7:0] payload_byte;
      logic       frame_done;
      status_type status;
      logic [31:0] opcode;
      logic [15:0] length;
      logic [15:0] counter;
      logic [31:0] stamp;
      logic [7:0]  source;
      logic [7:0]  dest;
   } result_type;

   typedef struct packed {
      logic       fire;
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

endpackage

// ===== sv/rfd_in_stage.sv =====
module rfd_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              out_free,
   output rfd_pkg::item_type item
);
   import rfd_pkg::*;

   logic       valid_ff;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       fire;

   assign fire       = valid_ff && out_free;
   assign req_tready = !valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         data_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign item.fire      = fire;
   assign item.data_byte = data_ff;
   assign item.last_byte = last_ff;

endmodule

// ===== sv/rfd_core.sv =====
module rfd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [7:0]          csr_data,
   input  rfd_pkg::item_type   item,
   output logic                res_valid,
   output rfd_pkg::result_type res
);
   import rfd_pkg::*;

   logic [7:0]  marker_ff;
   logic [15:0] byte_index_ff, byte_index_in;
   logic [7:0]  xor_ff, xor_in;
   logic [31:0] opcode_ff, opcode_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] counter_ff, counter_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [7:0]  source_ff, source_in;
   logic [7:0]  dest_ff, dest_in;
   logic [15:0] check_ff, check_in;
   logic [15:0] stamp_off;
   logic        payload;
   status_type  status;
   logic [7:0]  b;
   logic [15:0] i;

   assign b         = item.data_byte;
   assign i         = byte_index_ff;
   assign stamp_off = i - OFS_STAMP;
   assign payload   = i >= HDR_SIZE;

   always_comb begin
      opcode_in  = opcode_ff;
      length_in  = length_ff;
      counter_in = counter_ff;
      stamp_in   = stamp_ff;
      source_in  = source_ff;
      dest_in    = dest_ff;
      check_in   = check_ff;
      xor_in     = xor_ff;
      if (i != OFS_CHK && i != OFS_CHK + 16'd1) begin
         xor_in = xor_ff ^ b;
      end
      if (i < 16'd4) begin
         opcode_in[{i[1:0], 3'b000} +: 8] = b;
      end else if (i == OFS_LEN) begin
         length_in[7:0] = b;
      end else if (i == OFS_LEN + 16'd1) begin
         length_in[15:8] = b;
      end else if (i == OFS_CNT) begin
         counter_in[7:0] = b;
      end else if (i == OFS_CNT + 16'd1) begin
         counter_in[15:8] = b;
      end else if (i >= OFS_STAMP && i < OFS_STAMP + 16'd4) begin
         stamp_in[{stamp_off[1:0], 3'b000} +: 8] = b;
      end else if (i == OFS_SRC) begin
         source_in = b;
      end else if (i == OFS_DST) begin
         dest_in = b;
      end else if (i == OFS_CHK) begin
         check_in[7:0] = b;
      end else if (i == OFS_CHK + 16'd1) begin
         check_in[15:8] = b;
      end
      byte_index_in = (i != COUNT_MAX) ? i + 16'd1 : i;
   end

   always_comb begin
      status = ST_OK;
      if (byte_index_in < HDR_SIZE) begin
         status = ST_SHORT;
      end else if (opcode_in[31:24] != marker_ff) begin
         status = ST_OPCODE;
      end else if (length_in != byte_index_in) begin
         status = ST_LENGTH;
      end else if (check_in != {8'h00, xor_in}) begin
         status = ST_CHECKSUM;
      end
   end

   assign res_valid        = item.fire && (payload || item.last_byte);
   assign res.is_payload   = payload;
   assign res.payload_byte = payload ? b : 8'h00;
   assign res.frame_done   = item.last_byte;
   assign res.status       = item.last_byte ? status : ST_OK;
   assign res.opcode       = opcode_in;
   assign res.length       = length_in;
   assign res.counter      = counter_in;
   assign res.stamp        = stamp_in;
   assign res.source       = source_in;
   assign res.dest         = dest_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= MARKER_RESET;
      end else if (csr_valid) begin
         marker_ff <= csr_data;
      end
      if (reset || (item.fire && item.last_byte)) begin
         byte_index_ff <= '0;
         xor_ff        <= '0;
         opcode_ff     <= '0;
         length_ff     <= '0;
         counter_ff    <= '0;
         stamp_ff      <= '0;
         source_ff     <= '0;
         dest_ff       <= '0;
         check_ff      <= '0;
      end else if (item.fire) begin
         byte_index_ff <= byte_index_in;
         xor_ff        <= xor_in;
         opcode_ff     <= opcode_in;
         length_ff     <= length_in;
         counter_ff    <= counter_in;
         stamp_ff      <= stamp_in;
         source_ff     <= source_in;
         dest_ff       <= dest_in;
         check_ff      <= check_in;
      end
   end

`ifndef SYNTH
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      item.fire && item.last_byte |=> byte_index_ff == '0 && xor_ff == '0)
      else $error("frame state not cleared after last byte");

   a_status_only_on_last: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.frame_done |-> res.status == ST_OK)
      else $error("status reported before end of frame");

   a_payload_after_header: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.is_payload |-> byte_index_ff >= HDR_SIZE)
      else $error("payload flagged inside header");

   a_index_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !item.fire && !$past(reset) |=> $stable(byte_index_ff))
      else $error("byte count moved without a transaction");
`endif

endmodule

// ===== sv/rfd_out_stage.sv =====
module rfd_out_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               res_valid,
   input  rfd_pkg::result_type                res,
   output logic                               out_free,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rfd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser
);
   import rfd_pkg::*;

   logic       valid_ff;
   result_type res_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= res_valid;
      end
      if (out_free && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = res_ff.frame_done;
   assign rsp_tuser  = res_ff.is_payload;
   assign rsp_tdata  = {5'b00000, res_ff.dest, res_ff.source, res_ff.stamp,
                        res_ff.counter, res_ff.length, res_ff.opcode,
                        res_ff.status, res_ff.payload_byte};

endmodule

// ===== sv/response_frame_deframer.sv =====
// Channel   Direction  Handshake                 Contents
// req_      in         req_tvalid / req_tready   one frame byte, tlast on the final byte
// rsp_      out        rsp_tvalid / rsp_tready   payload byte or end-of-frame status
// csr_      in         csr_valid / csr_ready     response marker (opcode top byte)
//
// One byte per cycle sustained while rsp_tready is high: input register, one
// pass of header capture and checks, result register.
// A req byte passes the input register and then the result register to rsp_tvalid.
// Header bytes that are not last produce no rsp transaction.
// Synchronous active-high reset clears the frame state, marker returns to 0xF0.
// A stalled rsp side holds the result register; req_tready drops only when
// both the input and result registers are full.
module response_frame_deframer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] data_byte
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] payload_byte, [10:8] status, [42:11] opcode_out, [58:43] length_out,
   // [74:59] counter_out, [106:75] stamp_out, [114:107] source_out,
   // [122:115] dest_out, rest zero
   output logic [rfd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,  // [0] is_payload
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [7:0]                         csr_data
);
   import rfd_pkg::*;

   item_type   item;
   result_type res;
   logic       res_valid;
   logic       out_free;

   assign csr_ready = 1'b1;

   rfd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .out_free   (out_free),
      .item       (item)
   );

   rfd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   rfd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
